FILE: rtl/dxs_pkg.sv
// Shared types and constants for the descending exchange sorter.
package dxs_pkg;

   // Fixed field widths of one record.
   localparam int unsigned KEY_W = 32;
   localparam int unsigned TAG_W = 16;
   localparam int unsigned REC_W = KEY_W + TAG_W;

   // Default store capacity in records.
   localparam int unsigned MAX_RECORDS_DEF = 64;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_LOAD,
      S_INNER,
      S_WBACK,
      S_EMIT
   } seq_state_type;

endpackage

FILE: rtl/dxs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dxs_ram
   import dxs_pkg::*;
#(
   parameter int unsigned WIDTH = REC_W,
   parameter int unsigned DEPTH = MAX_RECORDS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/descending_exchange_sorter.sv
// Top level of the descending exchange sorter: record store, sort sequencer, output.
//
// Records are taken one per cycle while busy is low, each beat written straight into the
// record store, until a beat with req_last_record set ends the set; up to MAX_RECORDS
// records are kept and any further ones are dropped and reported on rsp_overflow_flag.
// The block then raises busy and runs the exchange sort with one shared signed comparator
// and the one-write, one-read record RAM, one compare per cycle while a pass scans the
// store, set by the single RAM read port. It then emits the n stored records on consecutive
// cycles, highest key first, each beat shown for exactly one cycle with rsp_strobe high
// and the final one marked by rsp_last_out.
// The result channel has no back-pressure: the receiver must take every beat as it comes.
// A new record may be started in the same cycle as the final result beat.
module descending_exchange_sorter
   import dxs_pkg::*;
#(
   parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [KEY_W-1:0] req_record_key,
   input  logic        [TAG_W-1:0] req_record_tag,
   input  logic                    req_last_record,
   output logic                    rsp_strobe,
   output logic signed [KEY_W-1:0] rsp_sorted_key,
   output logic        [TAG_W-1:0] rsp_sorted_tag,
   output logic                    rsp_last_out,
   output logic                    rsp_overflow_flag
);

   localparam int unsigned AW = $clog2(MAX_RECORDS);
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

   seq_state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [REC_W-1:0] cur_ff, cur_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]    cmp_addr_ff, cmp_addr_in;
   logic             strobe_ff, strobe_in;
   logic             last_ff, last_in;
   logic             ovf_ff, ovf_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [REC_W-1:0] ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [REC_W-1:0] ram_rdata;

   logic             accept;
   logic             issue_j;
   logic             more_i;
   logic             final_k;
   logic             swap;

   // Record store.
   dxs_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Decode of the loop conditions.
   assign accept  = start && (state_ff == S_IDLE);
   assign issue_j = (j_ff < count_ff);
   assign more_i  = ((CW+1)'(i_ff) + (CW+1)'(2)) < (CW+1)'(count_ff);
   assign final_k = (CW'(k_ff + CW'(1)) == count_ff);
   // The held record gives way when its key is lower than the one just read.
   assign swap    = $signed(cur_ff[REC_W-1 -: KEY_W]) < $signed(ram_rdata[REC_W-1 -: KEY_W]);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_last_record) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = (count_ff >= CW'(2)) ? S_LOAD : S_EMIT;
         end
         S_LOAD: begin
            state_in = S_INNER;
         end
         S_INNER: begin
            if (!issue_j) begin
               state_in = S_WBACK;
            end
         end
         S_WBACK: begin
            state_in = more_i ? S_LOAD : S_EMIT;
         end
         S_EMIT: begin
            if (final_k) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and store control for each state.
   always_comb begin
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      cur_in      = cur_ff;
      cmp_vld_in  = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      strobe_in   = 1'b0;
      last_in     = 1'b0;
      ovf_in      = ovf_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = cur_ff;
      ram_re      = 1'b0;
      ram_raddr   = '0;
      case (state_ff)
         S_IDLE: begin
            // Store the incoming beat, or note that it was dropped.
            if (accept) begin
               if (count_ff < CW'(MAX_RECORDS)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  ram_wdata = {req_record_key, req_record_tag};
                  count_in  = CW'(count_ff + CW'(1));
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         S_START: begin
            // Fetch the first record to hold, or go straight to output.
            i_in = '0;
            k_in = '0;
            if (count_ff >= CW'(2)) begin
               ram_re    = 1'b1;
               ram_raddr = '0;
            end
         end
         S_LOAD: begin
            cur_in = ram_rdata;
            j_in   = CW'(i_ff + CW'(1));
         end
         S_INNER: begin
            // Read one later record per cycle and compare the previous read.
            if (issue_j) begin
               ram_re      = 1'b1;
               ram_raddr   = j_ff[AW-1:0];
               cmp_vld_in  = 1'b1;
               cmp_addr_in = j_ff[AW-1:0];
               j_in        = CW'(j_ff + CW'(1));
            end
            if (cmp_vld_ff && swap) begin
               ram_we    = 1'b1;
               ram_waddr = cmp_addr_ff;
               ram_wdata = cur_ff;
               cur_in    = ram_rdata;
            end
         end
         S_WBACK: begin
            // Put the winner back at its position and fetch the next one.
            ram_we    = 1'b1;
            ram_waddr = i_ff[AW-1:0];
            ram_wdata = cur_ff;
            k_in      = '0;
            if (more_i) begin
               i_in      = CW'(i_ff + CW'(1));
               ram_re    = 1'b1;
               ram_raddr = i_in[AW-1:0];
            end
         end
         S_EMIT: begin
            // Read out one sorted record per cycle.
            ram_re    = 1'b1;
            ram_raddr = k_ff[AW-1:0];
            strobe_in = 1'b1;
            last_in   = final_k;
            ovf_in    = dropped_ff;
            k_in      = CW'(k_ff + CW'(1));
            if (final_k) begin
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         cmp_vld_ff <= cmp_vld_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Loop counters and payload registers.
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      cmp_addr_ff <= cmp_addr_in;
      last_ff     <= last_in;
      ovf_ff      <= ovf_in;
   end

   // Result beat: the flags are registered alongside the store's read data.
   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_sorted_key    = $signed(ram_rdata[REC_W-1 -: KEY_W]);
   assign rsp_sorted_tag    = ram_rdata[TAG_W-1:0];
   assign rsp_last_out      = strobe_ff && last_ff;
   assign rsp_overflow_flag = strobe_ff && ovf_ff;

   // A result beat always follows an output read from the previous cycle.
   a_strobe_from_emit : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("result beat without an output read");

   // The fill count never passes the store capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS))
      else $error("record count exceeds capacity");

   // A store write and a read in the same cycle never target the same entry.
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("store read and write hit the same entry");

   // After the final beat of a set the store is empty and the block is idle.
   a_set_closed : assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |-> (count_ff == '0) && !dropped_ff && (state_ff == S_IDLE || $past(start)))
      else $error("set not closed after final beat");

endmodule
